// File: src/hmlp_pkg.sv
// Shared constants, types and hash function for the linear-probe hash table
package hmlp_pkg;

  localparam int Capacity = 1024;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);

  localparam logic [31:0] FnvOffset = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdLookup = 2'd1;
  localparam logic [1:0] CmdRemove = 2'd2;

  localparam logic [1:0] StEmpty = 2'd0;
  localparam logic [1:0] StLive = 2'd1;
  localparam logic [1:0] StTomb = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic hash_step;  // one FNV byte round
    logic set_home;   // probe index := hash mod capacity
    logic rd;         // issue slot read at probe index
    logic advance;    // step probe index, count
    logic note_tomb;  // remember current index as first tombstone
    logic wr_live;    // write key/value live at target
    logic wr_val;     // update value at probe index
    logic wr_tomb;    // mark probe index tombstone
    logic use_tomb;   // target is remembered tombstone
    logic clr_busy;   // sweep: clear status at sweep index
    logic res_load;   // capture result
    logic res_found;
    logic res_value;  // result value from read data
    logic res_full;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] st;       // registered status of slot read
    logic       key_eq;   // registered key matches request
    logic       last;     // probe count reached capacity - 1 (last probe)
    logic       hash_done;
    logic       have_tomb;
    logic       sweep_done;
  } sts_t;

  // One FNV-1a round over one byte
  function automatic logic [31:0] fnv_round(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FnvPrime;
  endfunction

endpackage

// File: src/hash_map_linear_probe.sv
// Top level of the linear-probe hash table: controller plus datapath
// Usage:
//   Requests (command, key, value) enter on in_valid/in_stall; a request is
//   taken at an edge with in_valid high and in_stall low. Each request yields
//   exactly one result (found, result_value, status) on out_valid/out_stall.
//   Processing: the request is captured, the eight FNV-1a byte rounds run,
//   then each probed slot takes a registered memory read and a compare,
//   and finally the result is posted.
//   The per-slot read/compare loop over the single-port slot memory sets
//   the rate; one request is worked on at a time.
//   After reset the block runs a clearing pass over all 1024 slots of the slot
//   status memory, holding in_stall high.
//   When the receiver stalls, the result register holds its value and no
//   new request is finished until it is taken.
module hash_map_linear_probe (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [63:0] key,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [63:0] result_value,
  output logic        status
);

  hmlp_pkg::ctl_t ctl;
  hmlp_pkg::sts_t sts;

  hmlp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .ctl(ctl), .sts(sts)
  );

  hmlp_datapath u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts), .command(command), .key(key),
    .value(value), .found(found), .result_value(result_value), .status(status)
  );

endmodule

// File: src/hmlp_datapath.sv
// Datapath: request registers, FNV hash, slot memories, probe index, result
module hmlp_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  hmlp_pkg::ctl_t           ctl,
  output hmlp_pkg::sts_t           sts,
  input  logic [1:0]               command,
  input  logic [63:0]              key,
  input  logic [63:0]              value,
  output logic                     found,
  output logic [63:0]              result_value,
  output logic                     status
);

  logic [1:0]  cmd;
  logic [63:0] req_key;
  logic [63:0] req_val;
  logic [31:0] hash;
  logic [3:0]  byte_cnt;
  logic [hmlp_pkg::IdxW-1:0] idx;
  logic [hmlp_pkg::IdxW-1:0] tomb;
  logic                      have_tomb;
  logic [hmlp_pkg::CntW-1:0] probes;
  logic [hmlp_pkg::CntW-1:0] sweep;

  logic [1:0]  mem_st [hmlp_pkg::Capacity];
  logic [63:0] mem_key [hmlp_pkg::Capacity];
  logic [63:0] mem_val [hmlp_pkg::Capacity];

  logic [1:0]  rd_st;
  logic [63:0] rd_key;
  logic [63:0] rd_val;
  logic [hmlp_pkg::IdxW-1:0] tgt;
  logic [hmlp_pkg::IdxW-1:0] idx_inc;

  assign tgt = ctl.use_tomb ? tomb : idx;
  assign idx_inc = (idx == hmlp_pkg::IdxW'(hmlp_pkg::Capacity - 1)) ? '0 : idx + 1'b1;

  // Request capture, hash rounds, probe bookkeeping
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= command;
      req_key <= key;
      req_val <= value;
      hash <= hmlp_pkg::FnvOffset;
      byte_cnt <= '0;
      have_tomb <= 1'b0;
      probes <= '0;
    end
    if (ctl.hash_step) begin
      hash <= hmlp_pkg::fnv_round(hash, req_key[byte_cnt[2:0]*8 +: 8]);
      byte_cnt <= byte_cnt + 1'b1;
    end
    if (ctl.set_home) begin
      idx <= hmlp_pkg::IdxW'(hash % hmlp_pkg::Capacity);
    end
    if (ctl.advance) begin
      idx <= idx_inc;
      probes <= probes + 1'b1;
    end
    if (ctl.note_tomb) begin
      tomb <= idx;
      have_tomb <= 1'b1;
    end
  end

  // Sweep counter for the clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (ctl.clr_busy) begin
      sweep <= sweep + 1'b1;
    end
  end

  // Slot memories
  always_ff @(posedge clk) begin
    if (ctl.clr_busy) begin
      mem_st[sweep[hmlp_pkg::IdxW-1:0]] <= hmlp_pkg::StEmpty;
    end else if (ctl.wr_live) begin
      mem_st[tgt] <= hmlp_pkg::StLive;
    end else if (ctl.wr_tomb) begin
      mem_st[idx] <= hmlp_pkg::StTomb;
    end
    if (ctl.rd) begin
      rd_st <= mem_st[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_live) begin
      mem_key[tgt] <= req_key;
    end
    if (ctl.rd) begin
      rd_key <= mem_key[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_live || ctl.wr_val) begin
      mem_val[tgt] <= req_val;
    end
    if (ctl.rd) begin
      rd_val <= mem_val[idx];
    end
  end

  // Result register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      found <= ctl.res_found;
      result_value <= ctl.res_value ? rd_val : 64'd0;
      status <= ctl.res_full;
    end
  end

  assign sts.cmd = cmd;
  assign sts.st = rd_st;
  assign sts.key_eq = (rd_key == req_key);
  assign sts.last = (probes == hmlp_pkg::CntW'(hmlp_pkg::Capacity - 1));
  assign sts.hash_done = (byte_cnt == 4'd8);
  assign sts.have_tomb = have_tomb;
  assign sts.sweep_done = (sweep == hmlp_pkg::CntW'(hmlp_pkg::Capacity - 1));

endmodule

// File: src/hmlp_ctrl.sv
// Controller: sequences clear sweep, hashing, probe walk and result handshake
module hmlp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output hmlp_pkg::ctl_t ctl,
  input  hmlp_pkg::sts_t sts
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       live;
  logic       empty;

  assign live = (sts.st == hmlp_pkg::StLive);
  assign empty = (sts.st == hmlp_pkg::StEmpty);
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    ctl = '0;
    state_next = state;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_CLEAR: begin
        ctl.clr_busy = 1'b1;
        if (sts.sweep_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          ctl.load = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.hash_done) begin
          ctl.set_home = 1'b1;
          state_next = S_READ;
        end else begin
          ctl.hash_step = 1'b1;
        end
      end
      S_READ: begin
        ctl.rd = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = S_OUT;
        ctl.res_load = 1'b1;
        if (sts.cmd == hmlp_pkg::CmdInsert) begin
          if (live && sts.key_eq) begin
            ctl.wr_val = 1'b1;
            ctl.res_found = 1'b1;
          end else if (empty) begin
            ctl.wr_live = 1'b1;
            ctl.use_tomb = sts.have_tomb;
          end else if (sts.last) begin
            if (sts.have_tomb || !live) begin
              ctl.wr_live = 1'b1;
              ctl.use_tomb = sts.have_tomb;
            end else begin
              ctl.res_full = 1'b1;
            end
          end else begin
            ctl.res_load = 1'b0;
            ctl.note_tomb = !live && !sts.have_tomb;
            ctl.advance = 1'b1;
            state_next = S_READ;
          end
        end else if (sts.cmd == hmlp_pkg::CmdLookup || sts.cmd == hmlp_pkg::CmdRemove) begin
          if (live && sts.key_eq) begin
            ctl.res_found = 1'b1;
            ctl.res_value = (sts.cmd == hmlp_pkg::CmdLookup);
            ctl.wr_tomb = (sts.cmd == hmlp_pkg::CmdRemove);
          end else if (!empty && !sts.last) begin
            ctl.res_load = 1'b0;
            ctl.advance = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_OUT: begin
        if (!(out_valid && out_stall)) begin
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // A request is taken only in idle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_HASH))
    else $error("request accepted outside idle");
  // No request during the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("request possible during clear");
  // Memory writes never coincide with clearing
  assert property (@(posedge clk) disable iff (rst)
    ctl.clr_busy |-> !(ctl.wr_live || ctl.wr_tomb))
    else $error("write during clear");
  // A result is loaded only when the output register is free or in the evaluate state
  assert property (@(posedge clk) disable iff (rst)
    ctl.res_load |-> !(out_valid && out_stall) || state == S_EVAL)
    else $error("result overwrite");

endmodule
